/* hdl/lkvc_pkg.sv */
`timescale 1ns / 1ps

package lkvc_pkg;

   // Build defaults
   localparam int ENTRIES_DEFAULT    = 16;
   localparam int KEY_BITS_DEFAULT   = 16;
   localparam int VALUE_BITS_DEFAULT = 16;

   localparam int CAP_BITS = 5;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_SET = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   // Per-cell control, broadcast along the chain
   typedef struct packed {
      logic match_load;   // latch key compare for the item being accepted
      logic shift;        // move entries one cell down, up to the target cell
   } cell_ctl_type;

endpackage

/* hdl/lkvc_cell.sv */
`timescale 1ns / 1ps

module lkvc_cell #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 16,
   parameter int VALUE_BITS = 16,
   parameter int INDEX      = 0,
   parameter int FILL_BITS  = $clog2(ENTRIES + 1),
   parameter int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lkvc_pkg::cell_ctl_type      ctl,
   input  logic [FILL_BITS-1:0]        fill,
   input  logic [IDX_BITS-1:0]         target,
   input  logic [KEY_BITS-1:0]         cmp_key,
   input  logic [KEY_BITS-1:0]         left_key,
   input  logic [VALUE_BITS-1:0]       left_value,
   output logic [KEY_BITS-1:0]         key,
   output logic [VALUE_BITS-1:0]       value,
   output logic                        match
);
   import lkvc_pkg::*;

   localparam logic [FILL_BITS-1:0] MY_FILL = FILL_BITS'(INDEX);
   localparam logic [IDX_BITS-1:0]  MY_IDX  = IDX_BITS'(INDEX);

   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic                  match_ff;
   logic                  match_in;
   logic                  valid;
   logic                  move;

   // Cells are kept in recency order, so the first fill cells are live
   assign valid = (MY_FILL < fill);
   assign move  = ctl.shift && (MY_IDX <= target);

   always_comb begin
      match_in = match_ff;
      if (ctl.match_load) begin
         match_in = valid && (key_ff == cmp_key);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         key_ff   <= left_key;
         value_ff <= left_value;
      end
   end

   assign key   = key_ff;
   assign value = value_ff;
   assign match = match_ff;

endmodule

/* hdl/lru_key_value_cache.sv */
`timescale 1ns / 1ps

// Channel   Direction  Ports                                      Accepted when
// req       in         req_opcode, req_key, req_data_in           req_valid & req_ready
// rsp       out        rsp_hit, rsp_data_out, rsp_evicted         rsp_valid & rsp_ready
// csr       in         csr_capacity                               csr_valid & csr_ready
//
// Each item takes two steps: acceptance latches the key compare in every cell,
// and the commit step shifts the cell chain and loads the result register.
// The second step waits while the result register still holds an untaken item.
// Reset empties the cache and sets capacity to 16; csr writes are always taken.

module lru_key_value_cache #(
   parameter int ENTRIES    = lkvc_pkg::ENTRIES_DEFAULT,
   parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEFAULT,
   parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic [KEY_BITS-1:0]           req_key,
   input  logic [VALUE_BITS-1:0]         req_data_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic [VALUE_BITS-1:0]         rsp_data_out,
   output logic                          rsp_evicted,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lkvc_pkg::CAP_BITS-1:0] csr_capacity
);
   import lkvc_pkg::*;

   localparam int FILL_BITS = $clog2(ENTRIES + 1);
   localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // Organization: cell i holds the entry of recency rank i (0 = most recent).
   // A hit at cell p, or an insert whose free or victim cell is p, moves cells
   // 0..p-1 down by one and places the touched entry in cell 0. Ranks are thus
   // implicit in position and only a fill count is kept.

   state_type              state_ff, state_in;
   logic                   op_ff;
   logic [KEY_BITS-1:0]    key_ff;
   logic [VALUE_BITS-1:0]  data_ff;
   logic [CAP_BITS-1:0]    capacity_ff;
   logic [FILL_BITS-1:0]   fill_ff, fill_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff;
   logic [VALUE_BITS-1:0]  rsp_data_ff;
   logic                   rsp_evicted_ff;

   logic                   accept;
   logic                   commit;
   logic                   hit;
   logic                   evict;
   logic                   insert;
   logic [IDX_BITS-1:0]    hit_idx;
   logic [VALUE_BITS-1:0]  hit_value;
   logic [IDX_BITS-1:0]    target;
   logic [FILL_BITS-1:0]   eff_cap;
   logic [VALUE_BITS-1:0]  front_value;
   cell_ctl_type           ctl;

   logic [KEY_BITS-1:0]    cell_key   [ENTRIES];
   logic [VALUE_BITS-1:0]  cell_value [ENTRIES];
   logic                   cell_match [ENTRIES];

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Capacity of zero acts as one; above the cell count it saturates
   always_comb begin
      if (capacity_ff == '0) begin
         eff_cap = FILL_BITS'(1);
      end else if (int'(capacity_ff) > ENTRIES) begin
         eff_cap = FILL_BITS'(ENTRIES);
      end else begin
         eff_cap = FILL_BITS'(int'(capacity_ff));
      end
   end

   // At most one cell matches: keys in the cache are unique
   always_comb begin
      hit       = 1'b0;
      hit_idx   = '0;
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (cell_match[i]) begin
            hit       = 1'b1;
            hit_idx   = hit_idx | IDX_BITS'(i);
            hit_value = hit_value | cell_value[i];
         end
      end
   end

   assign evict  = (op_ff == OP_SET) && !hit && (fill_ff >= eff_cap);
   assign insert = (op_ff == OP_SET) && !hit && !evict;

   always_comb begin
      if (hit) begin
         target = hit_idx;
      end else if (evict) begin
         target = IDX_BITS'(fill_ff - FILL_BITS'(1));   // least recent live cell
      end else begin
         target = IDX_BITS'(fill_ff);                   // first free cell
      end
   end

   assign front_value = (op_ff == OP_SET) ? data_ff : hit_value;

   always_comb begin
      state_in     = state_ff;
      commit       = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               commit       = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl.match_load = accept;
      ctl.shift      = commit && (hit || (op_ff == OP_SET));
   end

   assign fill_in = (commit && insert) ? (fill_ff + FILL_BITS'(1)) : fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_capacity;
         end
      end
   end

   // Item and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_opcode;
         key_ff  <= req_key;
         data_ff <= req_data_in;
      end
      if (commit) begin
         rsp_hit_ff     <= hit;
         rsp_data_ff    <= ((op_ff == OP_GET) && hit) ? hit_value : '0;
         rsp_evicted_ff <= evict;
      end
   end

   // Cell chain; cell 0 is fed with the touched entry
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      logic [KEY_BITS-1:0]   left_key;
      logic [VALUE_BITS-1:0] left_value;

      if (g == 0) begin : g_head
         assign left_key   = key_ff;
         assign left_value = front_value;
      end else begin : g_body
         assign left_key   = cell_key[g-1];
         assign left_value = cell_value[g-1];
      end

      lkvc_cell #(
         .ENTRIES    (ENTRIES),
         .KEY_BITS   (KEY_BITS),
         .VALUE_BITS (VALUE_BITS),
         .INDEX      (g),
         .FILL_BITS  (FILL_BITS),
         .IDX_BITS   (IDX_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .fill       (fill_ff),
         .target     (target),
         .cmp_key    (req_key),
         .left_key   (left_key),
         .left_value (left_value),
         .key        (cell_key[g]),
         .value      (cell_value[g]),
         .match      (cell_match[g])
      );
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_evicted  = rsp_evicted_ff;

endmodule
